// ===== rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 message digest block.
// Holds the sequencer state type, round constants, initial hash values
// and the SHA-256 mixing functions. No dependencies.
package sha256_pkg;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Padding marker byte that follows the message
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Standard initial hash values
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/sha256_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when the read enable is high.
// No dependencies.
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sha256_message_digest.sv =====
// SHA-256 message digest, top level: byte intake, padding, compression
// sequencer and digest output. Depends on sha256_pkg and sha256_ram.
//
//  channel   | dir | tdata               | tuser          | tlast
//  ----------+-----+---------------------+----------------+----------------
//  s_axis    | in  | data_byte [7:0]     | has_byte       | end_of_message
//  m_axis    | out | digest_word [63:0]  | word_index[1:0]| last_word
//
// Bytes are taken while the sequencer is idle. A full block then runs
// the compression: chain load, 64 rounds and chain fold back into the
// chain RAM, paced by the one-round-per-cycle datapath and the single
// chain RAM read port. The end word adds the padding word writes, one or
// two compressions and the digest word reads. Reset needs no clearing
// pass: chain entries carry valid bits.
// A stalled output holds the digest sequencer; intake waits until done.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha256_pkg::state_t state_reg, state_next;

    logic [6:0]  cnt_reg, cnt_next;
    logic [60:0] byte_cnt_reg, byte_cnt_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic        first_pad_reg, first_pad_next;
    logic        extra_reg, extra_next;
    logic        fin_reg, fin_next;
    logic        end_pend_reg, end_pend_next;
    logic [7:0]  cv_valid_reg, cv_valid_next;
    logic [2:0]  cv_raddr_q_reg, cv_raddr_q_next;
    logic [1:0]  out_k_reg, out_k_next;
    logic [1:0]  out_step_reg, out_step_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] wv_reg [8];
    logic [31:0] wv_next [8];
    logic [31:0] sr_reg [16];
    logic [31:0] sr_next [16];
    logic [31:0] w_pre_reg, w_pre_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    // RAM ports
    logic        blk_we, blk_re;
    logic [3:0]  blk_waddr, blk_raddr;
    logic [31:0] blk_wdata, blk_rdata;
    logic        cv_we, cv_re;
    logic [2:0]  cv_waddr, cv_raddr;
    logic [31:0] cv_wdata, cv_rdata;

    // Datapath helpers
    logic        accept;
    logic        out_free;
    logic [5:0]  pos;
    logic [5:0]  pad_src;
    logic [4:0]  shamt;
    logic [60:0] cnt_inc;
    logic [31:0] byte_word;
    logic [31:0] pad_word;
    logic [63:0] bit_len;
    logic [31:0] chain_rd;
    logic [31:0] w_t;
    logic [31:0] t1;
    logic [31:0] t2;

    // Message block buffer
    sha256_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .re    (blk_re),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    // Chaining value store
    sha256_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_cv_ram (
        .clk   (clk),
        .we    (cv_we),
        .waddr (cv_waddr),
        .wdata (cv_wdata),
        .re    (cv_re),
        .raddr (cv_raddr),
        .rdata (cv_rdata)
    );

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == sha256_pkg::ST_IDLE);
    assign out_free      = ~m_tvalid_reg | m_axis_tready;

    // Byte placement within the current big-endian word
    assign pos       = byte_cnt_reg[5:0];
    assign shamt     = {~pos[1:0], 3'b000};
    assign cnt_inc   = byte_cnt_reg + 61'd1;
    assign pad_src   = s_axis_tuser ? cnt_inc[5:0] : pos;
    assign byte_word = ((pos[1:0] == 2'd0) ? 32'd0 : word_reg)
                       | ({24'd0, s_axis_tdata} << shamt);
    assign pad_word  = ((pos[1:0] == 2'd0) ? 32'd0 : word_reg)
                       | ({24'd0, sha256_pkg::PAD_BYTE} << shamt);
    assign bit_len   = {byte_cnt_reg, 3'b000};

    // Unwritten chain entries read as the initial hash
    assign chain_rd = cv_valid_reg[cv_raddr_q_reg] ? cv_rdata
                      : sha256_pkg::INIT_HASH[cv_raddr_q_reg];

    // Round datapath
    assign w_t = (cnt_reg[6:4] == 3'd0) ? blk_rdata : w_pre_reg;
    assign t1  = wv_reg[7] + sha256_pkg::big_sigma1(wv_reg[4])
                 + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
                 + sha256_pkg::ROUND_K[cnt_reg[5:0]] + w_t;
    assign t2  = sha256_pkg::big_sigma0(wv_reg[0])
                 + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                    ^ (wv_reg[1] & wv_reg[2]));

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        word_next       = word_reg;
        pad_idx_next    = pad_idx_reg;
        first_pad_next  = first_pad_reg;
        extra_next      = extra_reg;
        fin_next        = fin_reg;
        end_pend_next   = end_pend_reg;
        cv_valid_next   = cv_valid_reg;
        cv_raddr_q_next = cv_raddr_q_reg;
        out_k_next      = out_k_reg;
        out_step_next   = out_step_reg;
        hi_next         = hi_reg;
        wv_next         = wv_reg;
        sr_next         = sr_reg;
        w_pre_next      = w_pre_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;

        blk_we    = 1'b0;
        blk_waddr = pos[5:2];
        blk_wdata = byte_word;
        blk_re    = 1'b0;
        blk_raddr = 4'd0;
        cv_we     = 1'b0;
        cv_waddr  = cv_raddr_q_reg;
        cv_wdata  = chain_rd + wv_reg[0];
        cv_re     = 1'b0;
        cv_raddr  = cnt_reg[2:0];

        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser)
                    begin
                        // Pack byte, write word when it completes
                        word_next     = byte_word;
                        byte_cnt_next = cnt_inc;
                        blk_we        = (pos[1:0] == 2'd3);
                    end
                    if (s_axis_tuser && pos == 6'd63)
                    begin
                        end_pend_next = s_axis_tlast;
                        cnt_next      = 7'd0;
                        state_next    = sha256_pkg::ST_LOAD;
                    end
                    else if (s_axis_tlast)
                    begin
                        pad_idx_next   = pad_src[5:2];
                        first_pad_next = 1'b1;
                        extra_next     = &pad_src[5:3];
                        state_next     = sha256_pkg::ST_PAD;
                    end
                end
            end

            sha256_pkg::ST_PAD:
            begin
                // Write marker word if pending, zeros, then the bit length in the last block
                blk_we    = 1'b1;
                blk_waddr = pad_idx_reg;
                if (first_pad_reg)
                begin
                    blk_wdata = pad_word;
                end
                else if (!extra_reg && pad_idx_reg == 4'd14)
                begin
                    blk_wdata = bit_len[63:32];
                end
                else if (!extra_reg && pad_idx_reg == 4'd15)
                begin
                    blk_wdata = bit_len[31:0];
                end
                else
                begin
                    blk_wdata = 32'd0;
                end
                first_pad_next = 1'b0;
                pad_idx_next   = pad_idx_reg + 4'd1;
                if (pad_idx_reg == 4'd15)
                begin
                    fin_next   = ~extra_reg;
                    cnt_next   = 7'd0;
                    state_next = sha256_pkg::ST_LOAD;
                end
            end

            sha256_pkg::ST_LOAD:
            begin
                // Stream chain words into the working variables
                if (!cnt_reg[3])
                begin
                    cv_re           = 1'b1;
                    cv_raddr_q_next = cnt_reg[2:0];
                end
                if (cnt_reg[3:0] != 4'd0)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        wv_next[i] = wv_reg[i + 1];
                    end
                    wv_next[7] = chain_rd;
                end
                if (cnt_reg[3])
                begin
                    // Fetch the first schedule word for round zero
                    blk_re     = 1'b1;
                    blk_raddr  = 4'd0;
                    cnt_next   = 7'd0;
                    state_next = sha256_pkg::ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            sha256_pkg::ST_ROUND:
            begin
                // Prefetch the next block word for the first sixteen rounds
                if (cnt_reg[5:0] < 6'd15)
                begin
                    blk_re    = 1'b1;
                    blk_raddr = cnt_reg[3:0] + 4'd1;
                end
                // Advance the schedule window and precompute the next word
                for (int i = 0; i < 15; i++)
                begin
                    sr_next[i] = sr_reg[i + 1];
                end
                sr_next[15] = w_t;
                w_pre_next  = sha256_pkg::small_sigma1(sr_reg[15]) + sr_reg[10]
                              + sha256_pkg::small_sigma0(sr_reg[2]) + sr_reg[1];
                // One compression round
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                if (cnt_reg == 7'd63)
                begin
                    cnt_next   = 7'd0;
                    state_next = sha256_pkg::ST_FOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            sha256_pkg::ST_FOLD:
            begin
                // Read chain word, add working variable, write back next cycle
                if (!cnt_reg[3])
                begin
                    cv_re           = 1'b1;
                    cv_raddr_q_next = cnt_reg[2:0];
                end
                if (cnt_reg[3:0] != 4'd0)
                begin
                    cv_we                         = 1'b1;
                    cv_valid_next[cv_raddr_q_reg] = 1'b1;
                    for (int i = 0; i < 7; i++)
                    begin
                        wv_next[i] = wv_reg[i + 1];
                    end
                    wv_next[7] = wv_reg[0];
                end
                if (cnt_reg[3])
                begin
                    cnt_next = 7'd0;
                    if (fin_reg)
                    begin
                        fin_next      = 1'b0;
                        out_k_next    = 2'd0;
                        out_step_next = 2'd0;
                        state_next    = sha256_pkg::ST_OUT;
                    end
                    else if (extra_reg)
                    begin
                        // Second padding block: zeros and the length
                        extra_next     = 1'b0;
                        first_pad_next = 1'b0;
                        pad_idx_next   = 4'd0;
                        state_next     = sha256_pkg::ST_PAD;
                    end
                    else if (end_pend_reg)
                    begin
                        // Message ended on a block boundary
                        end_pend_next  = 1'b0;
                        first_pad_next = 1'b1;
                        extra_next     = 1'b0;
                        pad_idx_next   = pos[5:2];
                        state_next     = sha256_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            sha256_pkg::ST_OUT:
            begin
                case (out_step_reg)
                    2'd0:
                    begin
                        cv_re           = 1'b1;
                        cv_raddr        = {out_k_reg, 1'b0};
                        cv_raddr_q_next = {out_k_reg, 1'b0};
                        out_step_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        hi_next         = chain_rd;
                        cv_re           = 1'b1;
                        cv_raddr        = {out_k_reg, 1'b1};
                        cv_raddr_q_next = {out_k_reg, 1'b1};
                        out_step_next   = 2'd2;
                    end
                    default:
                    begin
                        // Hold the read data until the output register frees
                        if (out_free)
                        begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = {hi_reg, chain_rd};
                            m_tuser_next  = out_k_reg;
                            m_tlast_next  = (out_k_reg == 2'd3);
                            out_step_next = 2'd0;
                            out_k_next    = out_k_reg + 2'd1;
                            if (out_k_reg == 2'd3)
                            begin
                                // Return to the initial chain for the next message
                                cv_valid_next = 8'd0;
                                byte_cnt_next = 61'd0;
                                state_next    = sha256_pkg::ST_IDLE;
                            end
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_IDLE;
            cnt_reg       <= 7'd0;
            byte_cnt_reg  <= 61'd0;
            pad_idx_reg   <= 4'd0;
            first_pad_reg <= 1'b0;
            extra_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
            cv_valid_reg  <= 8'd0;
            out_k_reg     <= 2'd0;
            out_step_reg  <= 2'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            pad_idx_reg   <= pad_idx_next;
            first_pad_reg <= first_pad_next;
            extra_reg     <= extra_next;
            fin_reg       <= fin_next;
            end_pend_reg  <= end_pend_next;
            cv_valid_reg  <= cv_valid_next;
            out_k_reg     <= out_k_next;
            out_step_reg  <= out_step_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        cv_raddr_q_reg <= cv_raddr_q_next;
        hi_reg         <= hi_next;
        wv_reg         <= wv_next;
        sr_reg         <= sr_next;
        w_pre_reg      <= w_pre_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

    // Fold starts only right after the last round
    a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_FOLD && cnt_reg == 7'd0)
        |-> $past(state_reg == sha256_pkg::ST_ROUND && cnt_reg == 7'd63))
        else $error("fold entered without completing 64 rounds");

    // Block buffer is written only by intake or padding
    a_blk_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        blk_we |-> (state_reg == sha256_pkg::ST_IDLE || state_reg == sha256_pkg::ST_PAD))
        else $error("block buffer written during compression");

    // Chain store is written only while folding
    a_cv_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        cv_we |-> (state_reg == sha256_pkg::ST_FOLD))
        else $error("chain store written outside fold");

    // Last digest word carries index three
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("digest last mark and index disagree");

endmodule
